// ===== hw/rtl/lru_key_value_cache_macros.svh =====
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LKC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LKC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lkc_pkg.sv =====
// Shared types for the LRU key-value cache controller and datapath.
package lkc_pkg;

	localparam int unsigned CAP_W   = 5;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned CAP_RST = 16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} lkc_op_t;

	typedef struct packed {
		logic start;
		logic scan_rd;
		logic upd_rd;
		logic commit;
		logic load_out;
	} lkc_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_free;
	} lkc_sts_t;

endpackage

// ===== hw/rtl/lkc_ctrl.sv =====
// Sequencer for the LRU key-value cache: scan sweep, rank update sweep, commit, output.
module lkc_ctrl
	import lkc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  lkc_sts_t sts,
	output lkc_cmd_t cmd
);

	`include "lru_key_value_cache_macros.svh"

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_SWAIT = 6'b000100,
		ST_UPDT  = 6'b001000,
		ST_UWAIT = 6'b010000,
		ST_DONE  = 6'b100000
	} st_t;

	st_t state_q;
	st_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		s_tready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_SWAIT;
				end
			end
			ST_SWAIT: begin
				state_d = ST_UPDT;
			end
			ST_UPDT: begin
				cmd.upd_rd = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_UWAIT;
				end
			end
			ST_UWAIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LKC_ASSERT_NXT(a_start_scan, cmd.start, state_q == ST_SCAN, "accepted item did not start scan")
	`LKC_ASSERT_NXT(a_commit_once, cmd.commit, !cmd.commit && state_q == ST_DONE, "commit repeated")
	`LKC_ASSERT_NOW(a_rd_excl, cmd.scan_rd || cmd.upd_rd, !(cmd.scan_rd && cmd.upd_rd) && !s_tready, "sweep overlap")

endmodule

// ===== hw/rtl/lkc_dp.sv =====
// Datapath of the LRU key-value cache: key/value/rank memories, valid bits, sweeps, output register.
module lkc_dp
	import lkc_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 16
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  lkc_cmd_t         cmd,
	output lkc_sts_t         sts,
	input  logic             in_op,
	input  logic [KEY_W-1:0] in_key,
	input  logic [VAL_W-1:0] in_val,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_cap,
	output logic [CAP_W-1:0] cap,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_hit,
	output logic [VAL_W-1:0] out_value
);

	`include "lru_key_value_cache_macros.svh"

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned RW = IW;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CX = CW + 1;
	localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

	logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
	logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
	logic [RW-1:0]    rnk_mem [MAX_ENTRIES];

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0]          count_q;
	logic [CAP_W-1:0]       cap_q;
	logic [IW-1:0]          idx_q;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic             scan_s1;
	logic             upd_s1;
	logic [IW-1:0]    adr_s1;
	logic             vld_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] valm_s1;
	logic [RW-1:0]    rnk_s1;

	logic             hit_q;
	logic [IW-1:0]    hslot_q;
	logic [RW-1:0]    hrank_q;
	logic [VAL_W-1:0] hval_q;
	logic [IW-1:0]    vslot_q;
	logic             ffound_q;
	logic [IW-1:0]    fslot_q;

	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_value_q;

	logic [EW-1:0] cap_x;
	logic [EW-1:0] eff_x;
	logic          full;
	logic          touch;
	logic          insert;
	logic          evict;
	logic [IW-1:0] ins_slot;
	logic [CX-1:0] rnk_p1;
	logic [RW-1:0] rnk_new;
	logic          rd_en;

	logic [MAX_ENTRIES-1:0] vclr;
	logic [MAX_ENTRIES-1:0] vset;

	assign rd_en = cmd.scan_rd || cmd.upd_rd;

	assign cap_x = EW'(cap_q);
	assign eff_x = (cap_x == '0) ? EW'(1) :
		((cap_x > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_x);
	assign full  = EW'(count_q) >= eff_x;

	assign touch    = hit_q;
	assign insert   = !hit_q && (op_q == OP_PUT);
	assign evict    = insert && full;
	assign ins_slot = (evict && (!ffound_q || (vslot_q < fslot_q))) ? vslot_q : fslot_q;

	assign rnk_p1 = CX'(rnk_s1) + CX'(1);

	always_comb begin
		rnk_new = rnk_s1;
		if (touch) begin
			if (adr_s1 == hslot_q) begin
				rnk_new = '0;
			end else if (vld_s1 && (rnk_s1 < hrank_q)) begin
				rnk_new = rnk_s1 + RW'(1);
			end
		end else if (insert) begin
			if (adr_s1 == ins_slot) begin
				rnk_new = '0;
			end else if (vld_s1 && !(evict && (adr_s1 == vslot_q))) begin
				rnk_new = rnk_s1 + RW'(1);
			end
		end
	end

	// set wins over clear when the evicted slot is reused
	always_comb begin
		vclr = '0;
		vset = '0;
		if (evict) begin
			vclr[vslot_q] = 1'b1;
		end
		vset[ins_slot] = 1'b1;
	end

	assign sts.idx_last = idx_q == IW'(MAX_ENTRIES - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			key_mem[ins_slot] <= key_q;
		end
		if (rd_en) begin
			key_s1 <= key_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			val_mem[ins_slot] <= val_q;
		end else if (cmd.commit && touch && (op_q == OP_PUT)) begin
			val_mem[hslot_q] <= val_q;
		end
		if (rd_en) begin
			valm_s1 <= val_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			rnk_mem[adr_s1] <= rnk_new;
		end
		if (rd_en) begin
			rnk_s1 <= rnk_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			adr_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q];
		end
		if (cmd.start) begin
			op_q  <= in_op;
			key_q <= in_key;
			val_q <= in_val;
		end
		if (scan_s1 && vld_s1 && (key_s1 == key_q)) begin
			hslot_q <= adr_s1;
			hrank_q <= rnk_s1;
			hval_q  <= valm_s1;
		end
		if (scan_s1 && vld_s1 && (rnk_p1 == CX'(count_q))) begin
			vslot_q <= adr_s1;
		end
		if (scan_s1 && !vld_s1 && !ffound_q) begin
			fslot_q <= adr_s1;
		end
		if (cmd.load_out) begin
			out_hit_q   <= hit_q;
			out_value_q <= (op_q == OP_PUT) ? '0 : (hit_q ? hval_q : '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			scan_s1     <= 1'b0;
			upd_s1      <= 1'b0;
			hit_q       <= 1'b0;
			ffound_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			upd_s1  <= cmd.upd_rd;
			if (rd_en) begin
				idx_q <= sts.idx_last ? '0 : idx_q + IW'(1);
			end
			if (cmd.start) begin
				hit_q    <= 1'b0;
				ffound_q <= 1'b0;
			end else begin
				if (scan_s1 && vld_s1 && (key_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (scan_s1 && !vld_s1) begin
					ffound_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_W'(CAP_RST);
			valid_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_cap;
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit && insert) begin
			if (!evict) begin
				count_q <= count_q + CW'(1);
			end
			valid_q <= (valid_q & ~vclr) | vset;
		end
	end

	assign cap       = cap_q;
	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_value = out_value_q;

	`LKC_ASSERT_NOW(a_cnt_pop, 1'b1, $countones(valid_q) == 32'(count_q), "count differs from valid bits")
	`LKC_ASSERT_NXT(a_cnt_cap, cmd.commit, EW'(count_q) <= eff_x, "count above capacity after commit")
	`LKC_ASSERT_NXT(a_load_vld, cmd.load_out, out_valid_q, "result not presented after load")

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache with APB capacity register.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid/s_tready         tuser=op, tdata={value,key}
//  m_*       out  m_tvalid/m_tready         tuser=hit, tdata=read_value
//  apb       in   psel&penable&pwrite       capacity at byte address 0
//
// Each item takes a key/rank sweep and a rank update sweep,
// one entry per cycle through the single read port of each memory.
// Reset clears valid bits, entry count and control; capacity resets to 16.
// A capacity write empties the store at once.
// A finished result waits in the output register; the next item is taken meanwhile
// and stalls only at its own result hand-off.
module lru_key_value_cache
	import lkc_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic        m_tuser,   // [0] hit
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lkc_cmd_t         cmd;
	lkc_sts_t         sts;
	logic             cfg_we;
	logic [CAP_W-1:0] cap;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr == 2'b00);
	assign prdata = {{(32 - CAP_W){1'b0}}, cap};

	lkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkc_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_tuser),
		.in_key    (s_tdata[31:0]),
		.in_val    (s_tdata[63:32]),
		.cfg_we    (cfg_we),
		.cfg_cap   (pwdata[CAP_W-1:0]),
		.cap       (cap),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (m_tuser),
		.out_value (m_tdata)
	);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key-value cache: streamed get/put traffic with an LRU shadow.
module testbench;
	import lkc_pkg::*;

	localparam int unsigned SLOTS         = 16;
	localparam int unsigned ITEMS_PER_SET = 90;
	localparam int unsigned NUM_SETS      = 12;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned DRAIN_CYCLES  = 2 * SLOTS + 8;
	localparam int unsigned STALL_LIMIT   = 5000;
	localparam bit [1:0]    CAPACITY_ADDR = 2'd0;

	typedef struct {
		bit             hit;
		bit [VAL_W-1:0] read_value;
	} lookup_result_t;

	class lru_cache_shadow_t;
		bit [KEY_W-1:0] slot_key[SLOTS];
		bit [VAL_W-1:0] slot_value[SLOTS];
		bit             slot_valid[SLOTS];
		bit [3:0]       slot_rank[SLOTS];
		bit [4:0]       n_entries;
		bit [CAP_W-1:0] cap_bits = CAP_W'(CAP_RST);
		lookup_result_t pending_lookups[$];
		int errors, n_gets, n_puts, n_hits, n_evictions, n_checked;

		function void empty_store();
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				slot_rank[i]  = '0;
			end
			n_entries = '0;
		endfunction

		function void write_capacity(bit [CAP_W-1:0] v);
			cap_bits = v;
			empty_store();
		endfunction

		function bit [4:0] eff_capacity();
			if (cap_bits == 0)
				return 5'd1;
			if (cap_bits > SLOTS)
				return 5'(SLOTS);
			return cap_bits;
		endfunction

		function void promote(int s);
			bit [3:0] r;
			r = slot_rank[s];
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && slot_rank[i] < r)
					slot_rank[i]++;
			slot_rank[s] = '0;
		endfunction

		function int pending();
			return pending_lookups.size();
		endfunction

		function void note_request(lkc_op_t op, bit [KEY_W-1:0] k, bit [VAL_W-1:0] v);
			int s;
			lookup_result_t res;
			s = -1;
			for (int i = 0; i < SLOTS; i++)
				if (s < 0 && slot_valid[i] && slot_key[i] == k)
					s = i;
			res.hit = (s >= 0);
			res.read_value = '0;
			if (res.hit)
				n_hits++;
			if (op == OP_GET) begin
				n_gets++;
				if (s >= 0) begin
					promote(s);
					res.read_value = slot_value[s];
				end else begin
					res.read_value = '1;
				end
			end else begin
				n_puts++;
				if (s >= 0) begin
					slot_value[s] = v;
					promote(s);
				end else begin
					if (n_entries >= eff_capacity()) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (slot_valid[i] && {1'b0, slot_rank[i]} + 5'd1 == n_entries) begin
								slot_valid[i] = 1'b0;
								n_entries--;
								n_evictions++;
								break;
							end
						end
					end
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i])
							slot_rank[i]++;
					for (int i = 0; i < SLOTS; i++) begin
						if (!slot_valid[i]) begin
							slot_valid[i] = 1'b1;
							slot_key[i]   = k;
							slot_value[i] = v;
							slot_rank[i]  = '0;
							n_entries++;
							break;
						end
					end
				end
			end
			pending_lookups.push_back(res);
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_response(logic hit, logic [VAL_W-1:0] data);
			lookup_result_t e;
			if (pending_lookups.size() == 0) begin
				report($sformatf("result with nothing expected: hit=%b read_value=%h", hit, data));
				return;
			end
			e = pending_lookups.pop_front();
			n_checked++;
			if (hit !== e.hit)
				report($sformatf("hit %b, expected %b", hit, e.hit));
			if (data !== e.read_value)
				report($sformatf("read_value %h, expected %h", data, e.read_value));
		endtask

		task flush_leftovers();
			while (pending_lookups.size() > 0) begin
				void'(pending_lookups.pop_front());
				report("expected result never arrived");
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // [31:0] key, [63:32] value
	logic        s_tuser  = 1'b0; // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] read_value
	logic        m_tuser;         // [0] hit
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [1:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	lru_cache_shadow_t shadow = new();
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;
	bit hold_request = 1'b0;
	int stall_cycles = 0;
	int n_settings   = 1;

	lru_key_value_cache #(.MAX_ENTRIES(SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			shadow.check_response(m_tuser, m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// result side: ready bursts, random stalls, one long hold-off on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic send_request(lkc_op_t op, bit [KEY_W-1:0] key, bit [VAL_W-1:0] value);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {value, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		shadow.note_request(op, key, value);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (shadow.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(bit [CAP_W-1:0] cap);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= {27'($urandom), cap};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.write_capacity(cap);
		n_settings++;
	endtask

	task automatic run_random(int n_items);
		bit [KEY_W-1:0] key_pool[24];
		bit [KEY_W-1:0] key;
		bit [VAL_W-1:0] value;
		int span;
		lkc_op_t op;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 24; i++)
			key_pool[i] = $urandom;
		span = shadow.eff_capacity() + 4;
		for (int n = 0; n < n_items; n++) begin
			op = lkc_op_t'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, span - 1)];
			case ($urandom_range(0, 9))
				0: value = 32'h8000_0000;
				1: value = 32'h7FFF_FFFF;
				2: value = '1;
				3: value = '0;
				default: value = $urandom;
			endcase
			send_request(op, key, value);
		end
	endtask

	initial begin
		bit [CAP_W-1:0] cap_plan[NUM_SETS];
		cap_plan = '{5'd1, 5'd0, 5'd5, 5'd16, 5'd16, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd0, 5'd12};
		cap_plan[9]  = CAP_W'($urandom_range(0, 31));
		cap_plan[10] = CAP_W'($urandom_range(0, 31));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: miss on empty store, extreme keys and values, update in place
		send_request(OP_GET, 32'h0000_0000, 32'h5555_5555);
		send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h8000_0000, 32'h0);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
		send_request(OP_GET, 32'h0000_0000, 32'h0);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
		send_request(OP_GET, 32'h0000_0000, 32'h0);
		send_request(OP_GET, 32'h0000_0001, 32'h0);
		drain();

		// two slots: the touched entry survives, the other is evicted
		write_capacity(5'd2);
		send_request(OP_PUT, 32'd11, 32'hAAAA_0011);
		send_request(OP_PUT, 32'd22, 32'hBBBB_0022);
		send_request(OP_GET, 32'd11, 32'h0);
		send_request(OP_PUT, 32'd33, 32'hCCCC_0033);
		send_request(OP_GET, 32'd22, 32'h0);
		send_request(OP_GET, 32'd11, 32'h0);
		send_request(OP_PUT, 32'd22, 32'hDDDD_0022);
		send_request(OP_GET, 32'd33, 32'h0);
		drain();

		for (int ph = 0; ph < NUM_SETS; ph++) begin
			tx_idle_on = (ph < NUM_SETS - 2);
			rx_idle_on = (ph < NUM_SETS - 2);
			write_capacity(cap_plan[ph]);
			if (ph == 3)
				hold_request = 1'b1;
			run_random(ITEMS_PER_SET);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		shadow.flush_leftovers();
		$display("Ran %0d requests (%0d gets, %0d puts) over %0d capacity settings.",
			shadow.n_gets + shadow.n_puts, shadow.n_gets, shadow.n_puts, n_settings);
		$display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
			shadow.n_checked, shadow.n_hits, shadow.n_evictions, shadow.errors);
		if (shadow.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
